// File: design/ecal_pkg.sv
package ecal_pkg;

   // result field widths
   localparam int YEAR_W   = 13;
   localparam int MONTH_W  = 4;
   localparam int MDAY_W   = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int WDAY_W   = 3;
   localparam int YDAY_W   = 9;

   // width of the octal digit sum used for the weekday
   localparam int DSUM_W = 7;

   // offset from 1970-01-01 back to 1601-01-01 in seconds
   localparam logic [63:0] BIAS_TO_1601 = 64'd11644473600;

   // seconds per day is 675 << 7
   localparam logic [9:0]  DAY_SEC_ODD  = 10'd675;
   localparam int          DAY_SEC_SHIFT = 7;

   localparam logic [17:0] DAYS_400Y = 18'd146097;
   localparam logic [17:0] DAYS_100Y = 18'd36524;
   localparam logic [17:0] DAYS_200Y = 18'd73048;
   localparam logic [17:0] DAYS_300Y = 18'd109572;
   localparam logic [15:0] DAYS_4Y   = 16'd1461;
   localparam logic [10:0] DAYS_1Y   = 11'd365;
   localparam logic [10:0] DAYS_2Y   = 11'd730;
   localparam logic [10:0] DAYS_3Y   = 11'd1095;

   localparam logic [10:0] BASE_YEAR     = 11'd1601;
   localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
   localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
   localparam logic [4:0]  Q4_MAX        = 5'd24;

   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0] SECS_PER_MIN  = 12'd60;

   // reciprocal constants: floor(x / d) == (x * recip) >> shift over the value range
   localparam logic [17:0] HOUR_RECIP = 18'd149131;
   localparam int          HOUR_SHIFT = 29;
   localparam logic [16:0] C4Y_RECIP  = 17'd91868;
   localparam int          C4Y_SHIFT  = 27;
   localparam logic [12:0] MIN_RECIP  = 13'd4370;
   localparam int          MIN_SHIFT  = 18;

   localparam logic [8:0] CUM_DAYS [2][13] = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
   };

   // a value mod 7, from folding octal digits (8 is 1 mod 7)
   function automatic logic [2:0] mod7_fold(input logic [DSUM_W-1:0] value);
      logic [4:0] part;
      logic [3:0] rest;
      part = 5'(value[6:3]) + 5'(value[2:0]);
      rest = 4'(part[4:3]) + 4'(part[2:0]);
      if (rest >= 4'd7) begin
         rest = rest - 4'd7;
      end
      return rest[2:0];
   endfunction

endpackage

// File: design/epoch_seconds_to_calendar_unit.sv
// an accepted request beat passes through every stage, stage 1 to the response register
// throughput: one beat per cycle unless stalled; a stage advances whenever the one
// after it has room, so bubbles collapse and a held response still lets earlier stages fill
// the wide divide by seconds-per-day and by days-per-400-years are split multiplies
// over two stages each; they set the depth
// reset clears only the stage valid flags; payload registers are not reset
module epoch_seconds_to_calendar_unit #(
   parameter int SECONDS_WIDTH = 36
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SECONDS_WIDTH-1:0]            req_epoch_seconds,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ecal_pkg::YEAR_W-1:0]         rsp_year_number,
   output logic [ecal_pkg::MONTH_W-1:0]        rsp_month_number,
   output logic [ecal_pkg::MDAY_W-1:0]         rsp_day_of_month,
   output logic [ecal_pkg::HOUR_W-1:0]         rsp_hour_of_day,
   output logic [ecal_pkg::MINUTE_W-1:0]       rsp_minute_of_hour,
   output logic [ecal_pkg::SECOND_W-1:0]       rsp_second_of_minute,
   output logic [ecal_pkg::WDAY_W-1:0]         rsp_weekday,
   output logic [ecal_pkg::YDAY_W-1:0]         rsp_day_of_year,
   output logic                                rsp_leap_year
);

   localparam int NUM_ST = 11;

   localparam int SUM_W = ((SECONDS_WIDTH > 34) ? SECONDS_WIDTH : 34) + 1;
   localparam int T_W   = SUM_W - ecal_pkg::DAY_SEC_SHIFT;
   localparam int D_W   = T_W - 9;
   localparam int Q_W   = D_W - 17;
   localparam int Y_W   = (Q_W + 10 > ecal_pkg::YEAR_W) ? Q_W + 10 : ecal_pkg::YEAR_W;
   localparam int ND    = (D_W + 2) / 3;

   // days = t / 675 by reciprocal, split into four partial products
   localparam int          K1    = T_W + 10;
   localparam int          M1_W  = T_W + 1;
   localparam logic [63:0] M1    = ((64'd1 << K1) + 64'd674) / 64'd675;
   localparam int          TL_W  = T_W / 2;
   localparam int          TH_W  = T_W - TL_W;
   localparam int          ML_W  = (M1_W + 1) / 2;
   localparam int          MH_W  = M1_W - ML_W;
   localparam int          P1_W  = T_W + M1_W;
   localparam logic [ML_W-1:0] M1_LO = M1[ML_W-1:0];
   localparam logic [MH_W-1:0] M1_HI = M1[M1_W-1:ML_W];

   // q400 = days / 146097, same scheme
   localparam int          K2    = D_W + 18;
   localparam int          M2_W  = D_W + 1;
   localparam logic [63:0] M2    = ((64'd1 << K2) + 64'd146096) / 64'd146097;
   localparam int          DL_W  = D_W / 2;
   localparam int          DH_W  = D_W - DL_W;
   localparam int          NL_W  = (M2_W + 1) / 2;
   localparam int          NH_W  = M2_W - NL_W;
   localparam int          P2_W  = D_W + M2_W;
   localparam logic [NL_W-1:0] M2_LO = M2[NL_W-1:0];
   localparam logic [NH_W-1:0] M2_HI = M2[M2_W-1:NL_W];

   logic [NUM_ST-1:0] stage_valid_ff;
   logic [NUM_ST-1:0] adv;

   // stage 1
   logic [SUM_W-1:0]          s1_sec_ff, s1_sec_in;
   // stage 2
   logic [TL_W+ML_W-1:0]      s2_pll_ff, s2_pll_in;
   logic [TL_W+MH_W-1:0]      s2_plh_ff, s2_plh_in;
   logic [TH_W+ML_W-1:0]      s2_phl_ff, s2_phl_in;
   logic [TH_W+MH_W-1:0]      s2_phh_ff, s2_phh_in;
   logic [T_W-1:0]            s2_t_ff;
   logic [6:0]                s2_low_ff;
   // stage 3
   logic [D_W-1:0]            s3_days_ff, s3_days_in;
   logic [T_W-1:0]            s3_t_ff;
   logic [6:0]                s3_low_ff;
   // stage 4
   logic [DL_W+NL_W-1:0]      s4_pll_ff, s4_pll_in;
   logic [DL_W+NH_W-1:0]      s4_plh_ff, s4_plh_in;
   logic [DH_W+NL_W-1:0]      s4_phl_ff, s4_phl_in;
   logic [DH_W+NH_W-1:0]      s4_phh_ff, s4_phh_in;
   logic [17:0]               s4_days_ff;
   logic [16:0]               s4_sod_ff, s4_sod_in;
   logic [ecal_pkg::DSUM_W-1:0] s4_dsum_ff, s4_dsum_in;
   // stage 5
   logic [Q_W-1:0]            s5_q400_ff, s5_q400_in;
   logic [17:0]               s5_days_ff;
   logic [16:0]               s5_sod_ff;
   logic [2:0]                s5_wday_ff, s5_wday_in;
   // stage 6
   logic [17:0]               s6_r400_ff, s6_r400_in;
   logic [4:0]                s6_hour_ff, s6_hour_in;
   logic [16:0]               s6_sod_ff;
   logic [Q_W-1:0]            s6_q400_ff;
   logic [2:0]                s6_wday_ff;
   // stage 7
   logic [1:0]                s7_c100_ff, s7_c100_in;
   logic [15:0]               s7_r100_ff, s7_r100_in;
   logic [11:0]               s7_minrem_ff, s7_minrem_in;
   logic [4:0]                s7_hour_ff;
   logic [Q_W-1:0]            s7_q400_ff;
   logic [2:0]                s7_wday_ff;
   // stage 8
   logic [4:0]                s8_q4_ff, s8_q4_in;
   logic [5:0]                s8_minute_ff, s8_minute_in;
   logic [15:0]               s8_r100_ff;
   logic [11:0]               s8_minrem_ff;
   logic [1:0]                s8_c100_ff;
   logic [4:0]                s8_hour_ff;
   logic [Q_W-1:0]            s8_q400_ff;
   logic [2:0]                s8_wday_ff;
   // stage 9
   logic [10:0]               s9_r4_ff, s9_r4_in;
   logic [5:0]                s9_second_ff, s9_second_in;
   logic [4:0]                s9_q4_ff;
   logic [5:0]                s9_minute_ff;
   logic [1:0]                s9_c100_ff;
   logic [4:0]                s9_hour_ff;
   logic [Q_W-1:0]            s9_q400_ff;
   logic [2:0]                s9_wday_ff;
   // stage 10
   logic [8:0]                s10_yday_ff, s10_yday_in;
   logic                      s10_leap_ff, s10_leap_in;
   logic [Y_W-1:0]            s10_year_ff, s10_year_in;
   logic [5:0]                s10_second_ff;
   logic [5:0]                s10_minute_ff;
   logic [4:0]                s10_hour_ff;
   logic [2:0]                s10_wday_ff;
   // stage 11, the response register
   logic [ecal_pkg::YEAR_W-1:0]   rsp_year_ff;
   logic [ecal_pkg::MONTH_W-1:0]  rsp_month_ff, rsp_month_in;
   logic [ecal_pkg::MDAY_W-1:0]   rsp_mday_ff, rsp_mday_in;
   logic [ecal_pkg::HOUR_W-1:0]   rsp_hour_ff;
   logic [ecal_pkg::MINUTE_W-1:0] rsp_minute_ff;
   logic [ecal_pkg::SECOND_W-1:0] rsp_second_ff;
   logic [ecal_pkg::WDAY_W-1:0]   rsp_wday_ff;
   logic [ecal_pkg::YDAY_W-1:0]   rsp_yday_ff;
   logic                          rsp_leap_ff;

   // working values
   logic [T_W-1:0]     t_val;
   logic [P1_W-1:0]    prod1;
   logic [T_W-1:0]     t_rem;
   logic [3*ND-1:0]    days_pad;
   logic [P2_W-1:0]    prod2;
   logic [2:0]         wmod;
   logic [34:0]        hour_prod;
   logic [17:0]        cent_off;
   logic [32:0]        q4_prod;
   logic [4:0]         q4_raw;
   logic [24:0]        min_prod;
   logic [1:0]         a1;
   logic [10:0]        year_off;

   // a stage takes a new beat when it is empty or the stage after it moves on
   always_comb begin
      adv[NUM_ST-1] = !stage_valid_ff[NUM_ST-1] || !rsp_stall;
      for (int k = NUM_ST - 2; k >= 0; k--) begin
         adv[k] = !stage_valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = stage_valid_ff[NUM_ST-1];

   always_comb begin
      // stage 1: move the origin to 1601
      s1_sec_in = SUM_W'(req_epoch_seconds) + SUM_W'(ecal_pkg::BIAS_TO_1601);

      // stage 2: partial products of (seconds >> 7) * reciprocal of 675
      t_val     = s1_sec_ff[SUM_W-1:ecal_pkg::DAY_SEC_SHIFT];
      s2_pll_in = (TL_W+ML_W)'(t_val[TL_W-1:0]) * (TL_W+ML_W)'(M1_LO);
      s2_plh_in = (TL_W+MH_W)'(t_val[TL_W-1:0]) * (TL_W+MH_W)'(M1_HI);
      s2_phl_in = (TH_W+ML_W)'(t_val[T_W-1:TL_W]) * (TH_W+ML_W)'(M1_LO);
      s2_phh_in = (TH_W+MH_W)'(t_val[T_W-1:TL_W]) * (TH_W+MH_W)'(M1_HI);

      // stage 3: whole days
      prod1 = (P1_W'(s2_phh_ff) << (TL_W + ML_W)) + (P1_W'(s2_phl_ff) << TL_W)
            + (P1_W'(s2_plh_ff) << ML_W) + P1_W'(s2_pll_ff);
      s3_days_in = prod1[K1 +: D_W];

      // stage 4: second of day, octal digit sum of days, q400 partial products
      t_rem     = s3_t_ff - T_W'(s3_days_ff) * T_W'(ecal_pkg::DAY_SEC_ODD);
      s4_sod_in = {t_rem[9:0], s3_low_ff};
      days_pad  = (3*ND)'(s3_days_ff);
      s4_dsum_in = '0;
      for (int i = 0; i < ND; i++) begin
         s4_dsum_in = s4_dsum_in + ecal_pkg::DSUM_W'(days_pad[3*i +: 3]);
      end
      s4_pll_in = (DL_W+NL_W)'(s3_days_ff[DL_W-1:0]) * (DL_W+NL_W)'(M2_LO);
      s4_plh_in = (DL_W+NH_W)'(s3_days_ff[DL_W-1:0]) * (DL_W+NH_W)'(M2_HI);
      s4_phl_in = (DH_W+NL_W)'(s3_days_ff[D_W-1:DL_W]) * (DH_W+NL_W)'(M2_LO);
      s4_phh_in = (DH_W+NH_W)'(s3_days_ff[D_W-1:DL_W]) * (DH_W+NH_W)'(M2_HI);

      // stage 5: 400-year count and weekday (day 0 of 1601 was a monday)
      prod2 = (P2_W'(s4_phh_ff) << (DL_W + NL_W)) + (P2_W'(s4_phl_ff) << DL_W)
            + (P2_W'(s4_plh_ff) << NL_W) + P2_W'(s4_pll_ff);
      s5_q400_in = prod2[K2 +: Q_W];
      wmod       = ecal_pkg::mod7_fold(s4_dsum_ff);
      s5_wday_in = (wmod == 3'd6) ? 3'd0 : wmod + 3'd1;

      // stage 6: day within the era, hour of day
      s6_r400_in = s5_days_ff - 18'(s5_q400_ff) * ecal_pkg::DAYS_400Y;
      hour_prod  = 35'(s5_sod_ff) * 35'(ecal_pkg::HOUR_RECIP);
      s6_hour_in = hour_prod[ecal_pkg::HOUR_SHIFT +: 5];

      // stage 7: century, clamped so the era's last day stays in century 3
      if (s6_r400_ff >= ecal_pkg::DAYS_300Y) begin
         s7_c100_in = 2'd3;
         cent_off   = ecal_pkg::DAYS_300Y;
      end else if (s6_r400_ff >= ecal_pkg::DAYS_200Y) begin
         s7_c100_in = 2'd2;
         cent_off   = ecal_pkg::DAYS_200Y;
      end else if (s6_r400_ff >= ecal_pkg::DAYS_100Y) begin
         s7_c100_in = 2'd1;
         cent_off   = ecal_pkg::DAYS_100Y;
      end else begin
         s7_c100_in = 2'd0;
         cent_off   = '0;
      end
      s7_r100_in   = 16'(s6_r400_ff - cent_off);
      s7_minrem_in = 12'(s6_sod_ff - 17'(s6_hour_ff) * ecal_pkg::SECS_PER_HOUR);

      // stage 8: 4-year count, minute
      q4_prod  = 33'(s7_r100_ff) * 33'(ecal_pkg::C4Y_RECIP);
      q4_raw   = q4_prod[ecal_pkg::C4Y_SHIFT +: 5];
      s8_q4_in = (q4_raw > ecal_pkg::Q4_MAX) ? ecal_pkg::Q4_MAX : q4_raw;
      min_prod = 25'(s7_minrem_ff) * 25'(ecal_pkg::MIN_RECIP);
      s8_minute_in = min_prod[ecal_pkg::MIN_SHIFT +: 6];

      // stage 9: day within the 4-year span, second
      s9_r4_in     = 11'(s8_r100_ff - 16'(s8_q4_ff) * ecal_pkg::DAYS_4Y);
      s9_second_in = 6'(s8_minrem_ff - 12'(s8_minute_ff) * ecal_pkg::SECS_PER_MIN);

      // stage 10: year in span (clamped to 3), day of year, leap flag, year
      if (s9_r4_ff >= ecal_pkg::DAYS_3Y) begin
         a1       = 2'd3;
         year_off = ecal_pkg::DAYS_3Y;
      end else if (s9_r4_ff >= ecal_pkg::DAYS_2Y) begin
         a1       = 2'd2;
         year_off = ecal_pkg::DAYS_2Y;
      end else if (s9_r4_ff >= ecal_pkg::DAYS_1Y) begin
         a1       = 2'd1;
         year_off = ecal_pkg::DAYS_1Y;
      end else begin
         a1       = 2'd0;
         year_off = '0;
      end
      s10_yday_in = 9'(s9_r4_ff - year_off);
      // the fourth year of a span is leap, except at a century that is not an era end
      s10_leap_in = (a1 == 2'd3) &&
                    ((s9_q4_ff != ecal_pkg::Q4_MAX) || (s9_c100_ff == 2'd3));
      s10_year_in = Y_W'(ecal_pkg::BASE_YEAR)
                  + Y_W'(s9_q400_ff) * Y_W'(ecal_pkg::YEARS_PER_ERA)
                  + Y_W'(s9_c100_ff) * Y_W'(ecal_pkg::YEARS_PER_CENT)
                  + Y_W'({s9_q4_ff, 2'b00}) + Y_W'(a1);

      // stage 11: month and day of month, first month whose end lies past the day
      rsp_month_in = 4'd12;
      rsp_mday_in  = 5'd31;
      for (int m = 12; m >= 1; m--) begin
         if (s10_yday_ff < ecal_pkg::CUM_DAYS[s10_leap_ff][m]) begin
            rsp_month_in = 4'(m);
            rsp_mday_in  = 5'(s10_yday_ff - ecal_pkg::CUM_DAYS[s10_leap_ff][m-1] + 9'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            stage_valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_ST; k++) begin
            if (adv[k]) begin
               stage_valid_ff[k] <= stage_valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_sec_ff <= s1_sec_in;
      end
      if (adv[1]) begin
         s2_pll_ff <= s2_pll_in;
         s2_plh_ff <= s2_plh_in;
         s2_phl_ff <= s2_phl_in;
         s2_phh_ff <= s2_phh_in;
         s2_t_ff   <= t_val;
         s2_low_ff <= s1_sec_ff[6:0];
      end
      if (adv[2]) begin
         s3_days_ff <= s3_days_in;
         s3_t_ff    <= s2_t_ff;
         s3_low_ff  <= s2_low_ff;
      end
      if (adv[3]) begin
         s4_pll_ff  <= s4_pll_in;
         s4_plh_ff  <= s4_plh_in;
         s4_phl_ff  <= s4_phl_in;
         s4_phh_ff  <= s4_phh_in;
         s4_days_ff <= s3_days_ff[17:0];
         s4_sod_ff  <= s4_sod_in;
         s4_dsum_ff <= s4_dsum_in;
      end
      if (adv[4]) begin
         s5_q400_ff <= s5_q400_in;
         s5_days_ff <= s4_days_ff;
         s5_sod_ff  <= s4_sod_ff;
         s5_wday_ff <= s5_wday_in;
      end
      if (adv[5]) begin
         s6_r400_ff <= s6_r400_in;
         s6_hour_ff <= s6_hour_in;
         s6_sod_ff  <= s5_sod_ff;
         s6_q400_ff <= s5_q400_ff;
         s6_wday_ff <= s5_wday_ff;
      end
      if (adv[6]) begin
         s7_c100_ff   <= s7_c100_in;
         s7_r100_ff   <= s7_r100_in;
         s7_minrem_ff <= s7_minrem_in;
         s7_hour_ff   <= s6_hour_ff;
         s7_q400_ff   <= s6_q400_ff;
         s7_wday_ff   <= s6_wday_ff;
      end
      if (adv[7]) begin
         s8_q4_ff     <= s8_q4_in;
         s8_minute_ff <= s8_minute_in;
         s8_r100_ff   <= s7_r100_ff;
         s8_minrem_ff <= s7_minrem_ff;
         s8_c100_ff   <= s7_c100_ff;
         s8_hour_ff   <= s7_hour_ff;
         s8_q400_ff   <= s7_q400_ff;
         s8_wday_ff   <= s7_wday_ff;
      end
      if (adv[8]) begin
         s9_r4_ff     <= s9_r4_in;
         s9_second_ff <= s9_second_in;
         s9_q4_ff     <= s8_q4_ff;
         s9_minute_ff <= s8_minute_ff;
         s9_c100_ff   <= s8_c100_ff;
         s9_hour_ff   <= s8_hour_ff;
         s9_q400_ff   <= s8_q400_ff;
         s9_wday_ff   <= s8_wday_ff;
      end
      if (adv[9]) begin
         s10_yday_ff   <= s10_yday_in;
         s10_leap_ff   <= s10_leap_in;
         s10_year_ff   <= s10_year_in;
         s10_second_ff <= s9_second_ff;
         s10_minute_ff <= s9_minute_ff;
         s10_hour_ff   <= s9_hour_ff;
         s10_wday_ff   <= s9_wday_ff;
      end
      if (adv[10]) begin
         rsp_year_ff   <= s10_year_ff[ecal_pkg::YEAR_W-1:0];
         rsp_month_ff  <= rsp_month_in;
         rsp_mday_ff   <= rsp_mday_in;
         rsp_hour_ff   <= s10_hour_ff;
         rsp_minute_ff <= s10_minute_ff;
         rsp_second_ff <= s10_second_ff;
         rsp_wday_ff   <= s10_wday_ff;
         rsp_yday_ff   <= s10_yday_ff;
         rsp_leap_ff   <= s10_leap_ff;
      end
   end

   assign rsp_year_number      = rsp_year_ff;
   assign rsp_month_number     = rsp_month_ff;
   assign rsp_day_of_month     = rsp_mday_ff;
   assign rsp_hour_of_day      = rsp_hour_ff;
   assign rsp_minute_of_hour   = rsp_minute_ff;
   assign rsp_second_of_minute = rsp_second_ff;
   assign rsp_weekday          = rsp_wday_ff;
   assign rsp_day_of_year      = rsp_yday_ff;
   assign rsp_leap_year        = rsp_leap_ff;

endmodule

// File: design/ecal_checker.sv
module ecal_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ecal_pkg::YEAR_W-1:0]         rsp_year_number,
   input logic [ecal_pkg::MONTH_W-1:0]        rsp_month_number,
   input logic [ecal_pkg::MDAY_W-1:0]         rsp_day_of_month,
   input logic [ecal_pkg::HOUR_W-1:0]         rsp_hour_of_day,
   input logic [ecal_pkg::MINUTE_W-1:0]       rsp_minute_of_hour,
   input logic [ecal_pkg::SECOND_W-1:0]       rsp_second_of_minute,
   input logic [ecal_pkg::WDAY_W-1:0]         rsp_weekday,
   input logic [ecal_pkg::YDAY_W-1:0]         rsp_day_of_year,
   input logic                                rsp_leap_year
);

   // a held response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year_number)
         && $stable(rsp_day_of_year) && $stable(rsp_second_of_minute))
      else $error("held response beat changed");

   // reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the response side free, every stage can move, so requests flow
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_number >= 4'd1) && (rsp_month_number <= 4'd12)
         && (rsp_day_of_month >= 5'd1) && (rsp_hour_of_day < 5'd24)
         && (rsp_minute_of_hour < 6'd60) && (rsp_second_of_minute < 6'd60)
         && (rsp_weekday < 3'd7))
      else $error("response field out of range");

   // only a leap year has a day 365 or a february 29
   a_leap_days: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_leap_year |-> (rsp_day_of_year < 9'd365)
         && !((rsp_month_number == 4'd2) && (rsp_day_of_month == 5'd29)))
      else $error("leap day in a common year");

endmodule

bind epoch_seconds_to_calendar_unit ecal_checker u_ecal_checker (.*);

// File: dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECS_W = 36;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [ecal_pkg::YEAR_W-1:0]   year;
      logic [ecal_pkg::MONTH_W-1:0]  month;
      logic [ecal_pkg::MDAY_W-1:0]   mday;
      logic [ecal_pkg::HOUR_W-1:0]   hour;
      logic [ecal_pkg::MINUTE_W-1:0] minute;
      logic [ecal_pkg::SECOND_W-1:0] second;
      logic [ecal_pkg::WDAY_W-1:0]   wday;
      logic [ecal_pkg::YDAY_W-1:0]   yday;
      logic                          leap;
   } calendar_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SECS_W-1:0] req_epoch_seconds = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ecal_pkg::YEAR_W-1:0]   rsp_year_number;
   logic [ecal_pkg::MONTH_W-1:0]  rsp_month_number;
   logic [ecal_pkg::MDAY_W-1:0]   rsp_day_of_month;
   logic [ecal_pkg::HOUR_W-1:0]   rsp_hour_of_day;
   logic [ecal_pkg::MINUTE_W-1:0] rsp_minute_of_hour;
   logic [ecal_pkg::SECOND_W-1:0] rsp_second_of_minute;
   logic [ecal_pkg::WDAY_W-1:0]   rsp_weekday;
   logic [ecal_pkg::YDAY_W-1:0]   rsp_day_of_year;
   logic                          rsp_leap_year;

   calendar_type pending_dates[$];
   logic [SECS_W-1:0] pending_secs[$];
   int beats_sent = 0;
   int beats_checked = 0;
   int error_count = 0;
   int rsp_hold_left = 0;
   bit quiet = 1'b0;

   epoch_seconds_to_calendar_unit #(.SECONDS_WIDTH(SECS_W)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_year_number(rsp_year_number),
      .rsp_month_number(rsp_month_number),
      .rsp_day_of_month(rsp_day_of_month),
      .rsp_hour_of_day(rsp_hour_of_day),
      .rsp_minute_of_hour(rsp_minute_of_hour),
      .rsp_second_of_minute(rsp_second_of_minute),
      .rsp_weekday(rsp_weekday),
      .rsp_day_of_year(rsp_day_of_year),
      .rsp_leap_year(rsp_leap_year)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit is_leap(input longint unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   // days before the first of month m; m of 13 gives the year length
   function automatic int month_start(input bit leap, input int m);
      int d;
      case (m)
         1: d = 0;
         2: d = 31;
         3: d = 59;
         4: d = 90;
         5: d = 120;
         6: d = 151;
         7: d = 181;
         8: d = 212;
         9: d = 243;
         10: d = 273;
         11: d = 304;
         12: d = 334;
         default: d = 365;
      endcase
      return d + ((leap && m > 2) ? 1 : 0);
   endfunction

   function automatic calendar_type calendar_of(input logic [SECS_W-1:0] secs);
      longint unsigned s, q400, c100, q4, a1, yr, yd, part, mo, md;
      calendar_type c;
      bit found;
      s = 64'(secs) + 64'd11644473600;
      part = (s / 64'd86400 + 64'd1) % 64'd7;
      c.wday = part[ecal_pkg::WDAY_W-1:0];
      q400 = s / 64'd12622780800;
      s = s % 64'd12622780800;
      c100 = s / 64'd3155673600;
      if (c100 > 3) c100 = 3;
      s = s - c100 * 64'd3155673600;
      q4 = s / 64'd126230400;
      if (q4 > 24) q4 = 24;
      s = s - q4 * 64'd126230400;
      // last day of a leap span would otherwise roll into a fifth year
      a1 = s / 64'd31536000;
      if (a1 > 3) a1 = 3;
      s = s - a1 * 64'd31536000;
      yr = 64'd1601 + q400 * 400 + c100 * 100 + q4 * 4 + a1;
      c.year = yr[ecal_pkg::YEAR_W-1:0];
      c.leap = is_leap(yr);
      yd = s / 64'd86400;
      s = s % 64'd86400;
      c.yday = yd[ecal_pkg::YDAY_W-1:0];
      part = s / 64'd3600;
      c.hour = part[ecal_pkg::HOUR_W-1:0];
      s = s % 64'd3600;
      part = s / 64'd60;
      c.minute = part[ecal_pkg::MINUTE_W-1:0];
      part = s % 64'd60;
      c.second = part[ecal_pkg::SECOND_W-1:0];
      mo = 64'd12;
      md = 64'd31;
      found = 1'b0;
      for (int m = 1; m <= 12; m++) begin
         if (!found && yd < 64'(month_start(c.leap, m + 1))) begin
            found = 1'b1;
            mo = 64'(m);
            md = yd - 64'(month_start(c.leap, m)) + 64'd1;
         end
      end
      c.month = mo[ecal_pkg::MONTH_W-1:0];
      c.mday = md[ecal_pkg::MDAY_W-1:0];
      return c;
   endfunction

   function automatic longint days_to_year(input longint y);
      return 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
   endfunction

   function automatic logic [SECS_W-1:0] epoch_of(input int yr, input int mo, input int dy,
                                                  input int hh, input int mi, input int ss);
      longint d;
      d = days_to_year(yr) - days_to_year(1970) + month_start(is_leap(yr), mo) + dy - 1;
      return SECS_W'(d * 86400 + hh * 3600 + mi * 60 + ss);
   endfunction

   function automatic string date_text(input calendar_type c);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wday %0d yday %0d leap %0d",
                       c.year, c.month, c.mday, c.hour, c.minute, c.second,
                       c.wday, c.yday, c.leap);
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_seconds(input logic [SECS_W-1:0] secs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      pending_dates.push_back(calendar_of(secs));
      pending_secs.push_back(secs);
      beats_sent++;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   task automatic test_field_extremes();
      send_seconds('0);
      send_seconds(SECS_W'(86399));
      send_seconds(SECS_W'(86400));
      send_seconds(SECS_W'(64'h7FFF_FFFF));
      send_seconds(SECS_W'(64'hFFFF_FFFF));
      send_seconds(SECS_W'(64'h1_0000_0000));
      send_seconds('1);
      send_seconds(36'hAAAA_AAAAA);
      send_seconds(36'h5555_55555);
   endtask

   task automatic test_leap_and_century_edges();
      send_seconds(epoch_of(1972, 2, 29, 12, 34, 56));
      // last day of a leap span, year count clamps
      send_seconds(epoch_of(1972, 12, 31, 23, 59, 59));
      send_seconds(epoch_of(2000, 2, 29, 0, 0, 0));
      // last day of a 400-year cycle, century count clamps
      send_seconds(epoch_of(2000, 12, 31, 23, 59, 59));
      send_seconds(epoch_of(2001, 1, 1, 0, 0, 0));
      send_seconds(epoch_of(2100, 2, 28, 23, 59, 59));
      send_seconds(epoch_of(2100, 3, 1, 0, 0, 0));
      send_seconds(epoch_of(2096, 12, 31, 12, 0, 0));
      send_seconds(epoch_of(2400, 12, 31, 23, 59, 59));
   endtask

   task automatic test_weekdays();
      for (int d = 0; d < 7; d++) begin
         send_seconds(epoch_of(2024, 3, 3 + d, $urandom_range(0, 23),
                               $urandom_range(0, 59), $urandom_range(0, 59)));
      end
   endtask

   // receiver holds off long enough that the pipe fills and stalls the input
   task automatic test_back_pressure();
      drain_results();
      quiet = 1'b1;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) begin
         send_seconds(SECS_W'({$urandom(), $urandom()}));
      end
      quiet = 1'b0;
      drain_results();
   endtask

   task automatic test_random_uniform();
      logic [SECS_W-1:0] secs;
      int pick;
      for (int i = 0; i < 600; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) secs = SECS_W'($urandom_range(0, 200000));
         else if (pick == 1) secs = '1 - SECS_W'($urandom_range(0, 200000));
         else secs = SECS_W'({$urandom(), $urandom()});
         send_seconds(secs);
      end
   endtask

   task automatic test_random_boundaries();
      int yr, mo, dy, kind;
      bit leap;
      logic [SECS_W-1:0] secs;
      for (int i = 0; i < 600; i++) begin
         yr = $urandom_range(1970, 4146);
         if ($urandom_range(0, 3) == 0) yr = 100 * $urandom_range(20, 41);
         leap = is_leap(yr);
         kind = $urandom_range(0, 4);
         case (kind)
            0: secs = epoch_of(yr, 12, 31, 23, 59, $urandom_range(50, 59));
            1: secs = epoch_of(yr, 1, 1, 0, 0, $urandom_range(0, 9));
            2: secs = epoch_of(yr, 2, leap ? 29 : 28, $urandom_range(0, 23),
                               $urandom_range(0, 59), $urandom_range(0, 59));
            3: secs = epoch_of(yr, 3, 1, $urandom_range(0, 23),
                               $urandom_range(0, 59), $urandom_range(0, 59));
            default: begin
               mo = $urandom_range(1, 12);
               dy = month_start(leap, mo + 1) - month_start(leap, mo);
               secs = epoch_of(yr, mo, dy, $urandom_range(0, 23),
                               $urandom_range(0, 59), $urandom_range(0, 59));
            end
         endcase
         send_seconds(secs);
      end
   endtask

   task automatic test_quiet_streaming();
      quiet = 1'b1;
      for (int i = 0; i < 150; i++) begin
         send_seconds(SECS_W'({$urandom(), $urandom()}));
      end
      quiet = 1'b0;
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin
      calendar_type got, want;
      logic [SECS_W-1:0] secs;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_year_number, rsp_month_number, rsp_day_of_month, rsp_hour_of_day,
                 rsp_minute_of_hour, rsp_second_of_minute, rsp_weekday, rsp_day_of_year,
                 rsp_leap_year};
         if (pending_dates.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("result beat with nothing pending: %s",
                                            date_text(got));
         end else begin
            want = pending_dates.pop_front();
            secs = pending_secs.pop_front();
            beats_checked++;
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch for %0d s: expected %s", secs, date_text(want));
                  $display("   got %s", date_text(got));
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results still pending", pending_dates.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_leap_and_century_edges();
      test_weekdays();
      test_back_pressure();
      test_random_uniform();
      test_random_boundaries();
      test_quiet_streaming();
      drain_results();
      repeat (30) @(negedge clock);
      $display("covered %0d beats: field extremes, leap and century edges, every weekday,",
               beats_sent);
      $display("random and boundary dates, a %0d-cycle hold; %0d checked, %0d errors",
               HOLD_CYCLES, beats_checked, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
